// File: design/kdop_pkg.sv
`timescale 1ns / 1ps

package kdop_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int NDIR        = 26;
	localparam int DOT_W       = COORD_WIDTH + 2;
	localparam int MAG_W       = DOT_W - 1;
	localparam int FRAC_W      = 24;
	localparam int PROD_W      = MAG_W + FRAC_W;
	localparam int LIM_W       = 15;
	localparam int SQ_W        = 25;
	localparam int BND_W       = 24;
	localparam int EXT_W       = BND_W + 1;
	localparam int CMP_W       = (MAG_W + 1 > BND_W) ? MAG_W + 1 : BND_W;
	localparam int IN_TDATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;
	localparam int OP_W        = 2;
	localparam int CFG_IDX_W   = 2;

	localparam logic [FRAC_W-1:0] RECIP2_Q24 = 24'd11863283;
	localparam logic [FRAC_W-1:0] RECIP3_Q24 = 24'd9686330;
	localparam logic [SQ_W-1:0]   SQRT2_Q24  = 25'd23726566;
	localparam logic [SQ_W-1:0]   SQRT3_Q24  = 25'd29058991;

	localparam logic [LIM_W-1:0] ACC_LIMIT_RST = 15'd100;
	localparam logic [LIM_W-1:0] QRY_LIMIT_RST = 15'd10000;

	localparam logic signed [EXT_W-1:0] EXTENT_MIN = {1'b1, {(EXT_W-1){1'b0}}};

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_TEST  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACC_LIMIT = 2'd0,
		CFG_QRY_LIMIT = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic              neg;
		logic [PROD_W-1:0] prod;
	} proj_t;

	// direction component of entry idx: x outer, then y, then z, origin skipped
	function automatic int dir_comp(int idx, int axis);
		int k;
		int r;
		int dx;
		int dy;
		int dz;
		k = 0;
		r = 0;
		for (dx = -1; dx <= 1; dx++) begin
			for (dy = -1; dy <= 1; dy++) begin
				for (dz = -1; dz <= 1; dz++) begin
					if (dx != 0 || dy != 0 || dz != 0) begin
						if (k == idx) begin
							r = (axis == 0) ? dx : (axis == 1) ? dy : dz;
						end
						k++;
					end
				end
			end
		end
		return r;
	endfunction

	function automatic int dir_count(int idx);
		int n;
		n = 0;
		if (dir_comp(idx, 0) != 0) n++;
		if (dir_comp(idx, 1) != 0) n++;
		if (dir_comp(idx, 2) != 0) n++;
		return n;
	endfunction

	// round(lim * 256 * |d|) for a direction with n nonzero components
	function automatic logic [BND_W-1:0] bound_of(logic [LIM_W-1:0] lim, int n);
		logic [SQ_W-1:0]       s;
		logic [LIM_W+SQ_W-1:0] p;
		logic [BND_W-1:0]      r;
		s = (n == 2) ? SQRT2_Q24 : SQRT3_Q24;
		p = (LIM_W+SQ_W)'(lim) * (LIM_W+SQ_W)'(s)
			+ (LIM_W+SQ_W)'({1'b1, 15'd0});
		if (n == 1) r = BND_W'({lim, 8'd0});
		else r = BND_W'(p >> 16);
		return r;
	endfunction

endpackage

// File: design/kdop_proj.sv
`timescale 1ns / 1ps

module kdop_proj import kdop_pkg::*; (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic signed [COORD_WIDTH-1:0] y,
	input  logic signed [COORD_WIDTH-1:0] z,
	output proj_t                         proj_s2 [NDIR]
);

	logic signed [DOT_W-1:0] xe;
	logic signed [DOT_W-1:0] ye;
	logic signed [DOT_W-1:0] ze;
	logic [PROD_W-1:0]       prod_c [NDIR];
	logic                    neg_c  [NDIR];

	assign xe = DOT_W'(x);
	assign ye = DOT_W'(y);
	assign ze = DOT_W'(z);

	for (genvar g = 0; g < NDIR; g++) begin : g_dir
		localparam int DX = dir_comp(g, 0);
		localparam int DY = dir_comp(g, 1);
		localparam int DZ = dir_comp(g, 2);
		localparam int N  = dir_count(g);

		logic signed [DOT_W-1:0] tx;
		logic signed [DOT_W-1:0] ty;
		logic signed [DOT_W-1:0] tz;
		logic signed [DOT_W-1:0] dot;
		logic signed [DOT_W-1:0] abs_dot;
		logic [MAG_W-1:0]        mag;

		assign tx      = (DX > 0) ? xe : (DX < 0) ? -xe : DOT_W'(0);
		assign ty      = (DY > 0) ? ye : (DY < 0) ? -ye : DOT_W'(0);
		assign tz      = (DZ > 0) ? ze : (DZ < 0) ? -ze : DOT_W'(0);
		assign dot     = tx + ty + tz;
		assign abs_dot = dot[DOT_W-1] ? -dot : dot;
		assign mag     = abs_dot[MAG_W-1:0];
		assign neg_c[g] = dot[DOT_W-1];

		if (N == 1) begin : g_axis
			assign prod_c[g] = {mag, {FRAC_W{1'b0}}};
		end else if (N == 2) begin : g_edge
			assign prod_c[g] = PROD_W'(mag) * PROD_W'(RECIP2_Q24);
		end else begin : g_corner
			assign prod_c[g] = PROD_W'(mag) * PROD_W'(RECIP3_Q24);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NDIR; i++) begin
				proj_s2[i].neg  <= neg_c[i];
				proj_s2[i].prod <= prod_c[i];
			end
		end
	end

endmodule

// File: design/kdop26_bound_accumulate_test.sv
`timescale 1ns / 1ps
// A test item's result is held in the s1, s2 and output registers in turn.
// Throughput: one item per cycle unless a result stalls; extents update in stage s2.
// Clear and add items update the 26 extents and produce no result.
// Reset: extents go to the most negative value, accumulate_limit to 100,
// query_limit to 10000; pipeline and output are emptied.

module kdop26_bound_accumulate_test import kdop_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // coord_x, coord_y, coord_z
	input  logic [OP_W-1:0]        s_tuser,   // opcode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // inside_res, zero fill
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [LIM_W-1:0]       cfg_data
);

	logic                          v1_q;
	logic                          v2_q;
	logic                          out_valid_q;
	logic                          inside_q;
	op_t                           op_s1;
	op_t                           op_s2;
	logic signed [COORD_WIDTH-1:0] x_s1;
	logic signed [COORD_WIDTH-1:0] y_s1;
	logic signed [COORD_WIDTH-1:0] z_s1;
	proj_t                         proj_s2 [NDIR];
	logic [BND_W-1:0]              bnd_acc_q [3];
	logic [BND_W-1:0]              bnd_qry_q [3];
	logic signed [EXT_W-1:0]       ext_q  [NDIR];
	logic signed [EXT_W-1:0]       dist_c [NDIR];
	logic [NDIR-1:0]               lt;
	logic                          in_xfer;
	logic                          out_free;
	logic                          adv1;
	logic                          adv2;

	assign out_free  = !out_valid_q || m_tready;
	assign adv2      = v2_q && (op_s2 != OP_TEST || out_free);
	assign adv1      = v1_q && (!v2_q || adv2);
	assign s_tready  = !v1_q || adv1;
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(OUT_TDATA_W-1){1'b0}}, inside_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) v1_q <= 1'b1;
			else if (adv1) v1_q <= 1'b0;
			if (adv1) v2_q <= 1'b1;
			else if (adv2) v2_q <= 1'b0;
			if (adv2 && op_s2 == OP_TEST) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1 <= op_t'(s_tuser);
			x_s1  <= s_tdata[COORD_WIDTH-1:0];
			y_s1  <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
			z_s1  <= s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
		end
		if (adv1) op_s2 <= op_s1;
		if (adv2 && op_s2 == OP_TEST) inside_q <= ~|lt;
	end

	kdop_proj u_proj (
		.clk     (clk),
		.en      (adv1),
		.x       (x_s1),
		.y       (y_s1),
		.z       (z_s1),
		.proj_s2 (proj_s2)
	);

	// clamp bounds follow the limits; recompute on each register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 3; n++) begin
				bnd_acc_q[n] <= bound_of(ACC_LIMIT_RST, n + 1);
				bnd_qry_q[n] <= bound_of(QRY_LIMIT_RST, n + 1);
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACC_LIMIT: begin
					for (int n = 0; n < 3; n++) bnd_acc_q[n] <= bound_of(cfg_data, n + 1);
				end
				CFG_QRY_LIMIT: begin
					for (int n = 0; n < 3; n++) bnd_qry_q[n] <= bound_of(cfg_data, n + 1);
				end
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < NDIR; g++) begin : g_dist
		localparam int N = dir_count(g);

		logic [BND_W-1:0]        bsel;
		logic [PROD_W:0]         rnd;
		logic [CMP_W-1:0]        q;
		logic [CMP_W-1:0]        b;
		logic [CMP_W-1:0]        m;
		logic signed [EXT_W-1:0] mag_e;

		assign bsel  = (op_s2 == OP_ADD) ? bnd_acc_q[N-1] : bnd_qry_q[N-1];
		assign rnd   = {1'b0, proj_s2[g].prod}
			+ {{(PROD_W+1-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
		assign q     = CMP_W'(rnd[PROD_W:FRAC_W]);
		assign b     = CMP_W'(bsel);
		assign m     = (q > b) ? b : q;
		assign mag_e = {1'b0, m[BND_W-1:0]};
		assign dist_c[g] = proj_s2[g].neg ? -mag_e : mag_e;
		assign lt[g] = ext_q[g] < dist_c[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NDIR; i++) ext_q[i] <= EXTENT_MIN;
		end else if (adv2) begin
			case (op_s2)
				OP_CLEAR: begin
					for (int i = 0; i < NDIR; i++) ext_q[i] <= EXTENT_MIN;
				end
				OP_ADD: begin
					for (int i = 0; i < NDIR; i++) begin
						if (lt[i]) ext_q[i] <= dist_c[i];
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: design/kdop_checker.sv
`timescale 1ns / 1ps

module kdop_checker import kdop_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic in_xfer;

	assign in_xfer = s_tvalid && s_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:1] == '0)
		else $error("result fill bits not zero");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with free output");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_xfer && m_tready) ##1 (!in_xfer && m_tready) ##1 (!in_xfer && m_tready)
		|=> !m_tvalid)
		else $error("result appeared with no item in flight");

endmodule

bind kdop26_bound_accumulate_test kdop_checker u_kdop_checker (.*);
